/* hdl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
// No dependencies.
package sfr_pkg;

  localparam logic [2:0] REG_PAT_LO  = 3'd0;
  localparam logic [2:0] REG_PAT_HI  = 3'd1;
  localparam logic [2:0] REG_PAT_LEN = 3'd2;
  localparam logic [2:0] REG_REP_LO  = 3'd3;
  localparam logic [2:0] REG_REP_HI  = 3'd4;
  localparam logic [2:0] REG_REP_LEN = 3'd5;

  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_EOL  = 1'b1;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Pick byte i of a 16-byte register pair.
  function automatic logic [7:0] byte_sel(input logic [127:0] v, input logic [3:0] i);
    byte_sel = v[{i, 3'b000} +: 8];
  endfunction

endpackage

/* hdl/sfr_queue.sv */
// Small FIFO decoupling the input side from the matching engine.
// Depends on sfr_pkg.
module sfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::in_item_t push_data,
  output logic              full,
  input  logic              pop,
  output sfr_pkg::in_item_t pop_data,
  output logic              empty
);

  sfr_pkg::in_item_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full     = (cnt_r == 3'd4);
  assign empty    = (cnt_r == 3'd0);
  assign pop_data = mem_r[rp_r];

  // Store requests and advance pointers
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 2'd1;
      if (pop && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

/* hdl/sfr_engine.sv */
// Matching engine: fallback walk, prefix re-emit, replacement and output register.
// Also rebuilds the failure table after pattern writes. Depends on sfr_pkg.
module sfr_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [127:0]      pat,
  input  logic [4:0]        pat_len,
  input  logic [127:0]      rep,
  input  logic [4:0]        rep_len,
  input  logic              pat_wr,
  input  logic              q_valid,
  input  sfr_pkg::in_item_t q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output sfr_pkg::out_item_t out_item
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DROP = 3'd2;
  localparam logic [2:0] S_REP  = 3'd3;
  localparam logic [2:0] S_EOL  = 3'd4;
  localparam logic [2:0] S_NL   = 3'd5;
  localparam logic [2:0] S_BLD  = 3'd6;

  logic [3:0]  ftab_r [16];
  logic [2:0]  st_r, st_nxt;
  logic [4:0]  m_r, m_nxt;       // committed match length
  logic [4:0]  w_r, w_nxt;       // walking match length
  logic [4:0]  old_r, old_nxt;
  logic [4:0]  i_r, i_nxt;       // emit index
  logic [4:0]  drop_r, drop_nxt;
  logic [7:0]  c_r, c_nxt;
  logic [4:0]  bi_r, bi_nxt;     // table build index
  logic [4:0]  bk_r, bk_nxt;
  logic        ob_v_r, ob_v_nxt;
  sfr_pkg::out_item_t ob_r, ob_nxt;
  logic        ft_we;
  logic [3:0]  ft_wa, ft_wd;

  logic [4:0] plen, rlen;
  assign plen = (pat_len > 5'd16) ? 5'd16 : pat_len;
  assign rlen = (rep_len > 5'd16) ? 5'd16 : rep_len;

  assign out_empty = !ob_v_r;
  assign out_item  = ob_r;

  logic can_emit;
  assign can_emit = !ob_v_r || out_pop;

  logic [7:0] pw, pbi, pbk;
  assign pw  = sfr_pkg::byte_sel(pat, w_r[3:0]);
  assign pbi = sfr_pkg::byte_sel(pat, bi_r[3:0]);
  assign pbk = sfr_pkg::byte_sel(pat, bk_r[3:0]);

  // Sequence one request through walk, drop, replace and end-of-line steps; also build the table
  always_comb begin
    st_nxt = st_r; m_nxt = m_r; w_nxt = w_r; old_nxt = old_r; i_nxt = i_r;
    drop_nxt = drop_r; c_nxt = c_r; bi_nxt = bi_r; bk_nxt = bk_r;
    ob_v_nxt = ob_v_r && !out_pop; ob_nxt = ob_r;
    q_pop = 1'b0; ft_we = 1'b0; ft_wa = bi_r[3:0]; ft_wd = '0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          c_nxt = q_data.data_byte;
          w_nxt = (m_r >= plen) ? 5'd0 : m_r;
          old_nxt = w_nxt;
          i_nxt = '0;
          if (q_data.func == sfr_pkg::FUNC_EOL) st_nxt = S_EOL;
          else if (plen == 5'd0) begin
            drop_nxt = 5'd1; old_nxt = '0; st_nxt = S_DROP;
          end else st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (w_r != 5'd0 && pw != c_r) w_nxt = {1'b0, ftab_r[4'(w_r - 5'd1)]};
        else begin
          if (pw == c_r) w_nxt = w_r + 5'd1;
          drop_nxt = old_r + 5'd1 - w_nxt;
          m_nxt = w_nxt;
          st_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (i_r == drop_r) begin
          i_nxt = '0;
          if (plen != 5'd0 && m_r == plen) begin
            m_nxt = '0; st_nxt = (rlen == 5'd0) ? S_IDLE : S_REP;
          end else st_nxt = S_IDLE;
        end else if (can_emit) begin
          ob_v_nxt = 1'b1;
          ob_nxt.out_byte = (i_r < old_r) ? sfr_pkg::byte_sel(pat, i_r[3:0]) : c_r;
          ob_nxt.last_of_run = (i_r + 5'd1 == drop_r) &&
                               !(plen != 5'd0 && m_r == plen && rlen != 5'd0);
          i_nxt = i_r + 5'd1;
        end
      end
      S_REP: begin
        if (can_emit) begin
          ob_v_nxt = 1'b1;
          ob_nxt.out_byte = sfr_pkg::byte_sel(rep, i_r[3:0]);
          ob_nxt.last_of_run = (i_r + 5'd1 == rlen);
          i_nxt = i_r + 5'd1;
          if (i_r + 5'd1 == rlen) st_nxt = S_IDLE;
        end
      end
      S_EOL: begin
        if (i_r == old_r) st_nxt = S_NL;
        else if (can_emit) begin
          ob_v_nxt = 1'b1;
          ob_nxt.out_byte = sfr_pkg::byte_sel(pat, i_r[3:0]);
          ob_nxt.last_of_run = 1'b0;
          i_nxt = i_r + 5'd1;
        end
      end
      S_NL: begin
        if (can_emit) begin
          ob_v_nxt = 1'b1;
          ob_nxt.out_byte = sfr_pkg::NEWLINE;
          ob_nxt.last_of_run = 1'b1;
          m_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      S_BLD: begin
        // One failure-table step per cycle
        if (bi_r >= plen || bi_r == 5'd16) st_nxt = S_IDLE;
        else if (bk_r != 5'd0 && pbi != pbk) bk_nxt = {1'b0, ftab_r[4'(bk_r - 5'd1)]};
        else begin
          ft_we = 1'b1;
          ft_wd = (pbi == pbk) ? 4'(bk_r + 5'd1) : bk_r[3:0];
          bk_nxt = {1'b0, ft_wd};
          bi_nxt = bi_r + 5'd1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // Restart the build; the first table entry is always zero
    if (pat_wr) begin
      st_nxt = S_BLD; m_nxt = '0; bi_nxt = 5'd1; bk_nxt = '0;
      ft_we = 1'b1; ft_wa = 4'd0; ft_wd = 4'd0;
    end
  end

  // Hold state, table and output register
  always_ff @(posedge clk) begin
    if (ft_we) ftab_r[ft_wa] <= ft_wd;
    ob_r <= ob_nxt; w_r <= w_nxt; old_r <= old_nxt; i_r <= i_nxt;
    drop_r <= drop_nxt; c_r <= c_nxt; bi_r <= bi_nxt; bk_r <= bk_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; m_r <= '0; ob_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; m_r <= m_nxt; ob_v_r <= ob_v_nxt;
    end
  end

endmodule

/* hdl/stream_find_and_replace.sv */
// Top level of the stream find-and-replace block.
// Depends on sfr_pkg, sfr_queue and sfr_engine.
//
// Usage:
//   Input is a queue: drive in_data and push; a request is taken when
//   push is high and full is low. Requests are text bytes or end of line.
//   Results are a queue: while empty is low, out_data holds the oldest
//   byte; pop takes it. last_of_run marks the final byte of one request.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_wdata, to be
//   written only while the block is idle. A pattern write clears the match
//   and rebuilds the failure table, one step per pattern byte plus one per
//   fallback step.
// Flow:
//   Four-deep input queue feeds the engine. A text byte is dequeued, then
//   walked through its fallback steps; its dropped bytes are emitted and
//   the drop run closed. End of line re-emits the held prefix and a newline.
// Reset clears the match, queue and output register and builds an empty
// table. A stalled receiver (pop low) holds the engine's emit steps while
// the output register is full; the queue still takes requests until full.
module stream_find_and_replace (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfr_pkg::in_item_t  in_data,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output sfr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic [63:0] pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [4:0]  pat_len_r, rep_len_r;
  logic        cfg_we, pat_wr;
  logic        q_valid_n, q_pop;
  sfr_pkg::in_item_t q_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign pat_wr    = cfg_we && (cfg_index == sfr_pkg::REG_PAT_LO ||
                                cfg_index == sfr_pkg::REG_PAT_HI ||
                                cfg_index == sfr_pkg::REG_PAT_LEN);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0; pat_hi_r <= '0; pat_len_r <= '0;
      rep_lo_r <= '0; rep_hi_r <= '0; rep_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::REG_PAT_LO:  pat_lo_r  <= cfg_wdata;
        sfr_pkg::REG_PAT_HI:  pat_hi_r  <= cfg_wdata;
        sfr_pkg::REG_PAT_LEN: pat_len_r <= cfg_wdata[4:0];
        sfr_pkg::REG_REP_LO:  rep_lo_r  <= cfg_wdata;
        sfr_pkg::REG_REP_HI:  rep_hi_r  <= cfg_wdata;
        sfr_pkg::REG_REP_LEN: rep_len_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  sfr_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(in_data), .full(full),
    .pop(q_pop), .pop_data(q_data), .empty(q_valid_n)
  );

  sfr_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .pat({pat_hi_r, pat_lo_r}), .pat_len(pat_len_r),
    .rep({rep_hi_r, rep_lo_r}), .rep_len(rep_len_r),
    .pat_wr(pat_wr || !rst_n),
    .q_valid(!q_valid_n), .q_data(q_data), .q_pop(q_pop),
    .out_empty(empty), .out_pop(pop), .out_item(out_data)
  );

endmodule

/* test/tb_stream_find_and_replace.sv */
// Testbench for stream_find_and_replace: directed table, then random phases,
// each result checked against a behavioral rewrite predictor.
// Depends on sfr_pkg and the stream_find_and_replace RTL.
`timescale 1ns / 1ps

module tb_stream_find_and_replace;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int NUM_RANDOM = 280;
  localparam int QUIET_TAIL = 40;
  localparam int SETTLE_CYCLES = 60;

  typedef enum logic [1:0] {ROW_TEXT, ROW_EOL, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data;
    logic [2:0]  idx;
    logic [63:0] wdata;
    bit          typed;
    logic [7:0]  typed_byte;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  sfr_pkg::in_item_t  in_data = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  sfr_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  // Predictor copy of registers and match state
  logic [127:0] pat_bytes;
  logic [127:0] rep_bytes;
  logic [4:0]   pat_len_reg;
  logic [4:0]   rep_len_reg;
  logic [4:0]   match_len;
  logic [3:0]   fallback [16];

  sfr_pkg::out_item_t pending_bytes [$];
  stim_row_t    rows [$];
  int           errors = 0;
  int           results_checked = 0;
  int           requests_sent = 0;
  int           phases = 0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;

  stream_find_and_replace DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .in_data(in_data), .full(full),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] pat_at(int i);
    return pat_bytes[i*8 +: 8];
  endfunction

  function automatic int eff_pat_len();
    return (pat_len_reg > 16) ? 16 : int'(pat_len_reg);
  endfunction

  // Recompute the failure table of the current pattern
  function automatic void rebuild_fallback();
    int len;
    int k;
    len = eff_pat_len();
    k = 0;
    for (int i = 0; i < 16; i++) fallback[i] = '0;
    for (int i = 1; i < len; i++) begin
      while (k > 0 && pat_at(i) != pat_at(k)) k = int'(fallback[k-1]);
      if (pat_at(i) == pat_at(k)) k++;
      fallback[i] = k[3:0];
    end
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [63:0] v);
    case (idx)
      sfr_pkg::REG_PAT_LO:  pat_bytes[63:0] = v;
      sfr_pkg::REG_PAT_HI:  pat_bytes[127:64] = v;
      sfr_pkg::REG_PAT_LEN: pat_len_reg = v[4:0];
      sfr_pkg::REG_REP_LO:  rep_bytes[63:0] = v;
      sfr_pkg::REG_REP_HI:  rep_bytes[127:64] = v;
      sfr_pkg::REG_REP_LEN: rep_len_reg = v[4:0];
      default: return;
    endcase
    if (idx == sfr_pkg::REG_PAT_LO || idx == sfr_pkg::REG_PAT_HI ||
        idx == sfr_pkg::REG_PAT_LEN) begin
      match_len = '0;
      rebuild_fallback();
    end
  endfunction

  function automatic void emit_byte(logic [7:0] b, ref int n);
    sfr_pkg::out_item_t o;
    o.out_byte = b;
    o.last_of_run = 1'b0;
    pending_bytes.push_back(o);
    n++;
  endfunction

  // Append the rewritten bytes that one request produces
  function automatic void rewrite_request(sfr_pkg::in_item_t r);
    int len;
    int m;
    int old;
    int drop;
    int rl;
    int n;
    len = eff_pat_len();
    m = int'(match_len);
    n = 0;
    if (m >= len) m = 0;
    if (r.func == sfr_pkg::FUNC_EOL) begin
      for (int i = 0; i < m; i++) emit_byte(pat_at(i), n);
      emit_byte(sfr_pkg::NEWLINE, n);
      m = 0;
    end else if (len == 0) begin
      emit_byte(r.data_byte, n);
    end else begin
      old = m;
      while (m > 0 && pat_at(m) != r.data_byte) m = int'(fallback[m-1]);
      if (pat_at(m) == r.data_byte) m++;
      drop = old + 1 - m;
      for (int i = 0; i < drop; i++) emit_byte((i < old) ? pat_at(i) : r.data_byte, n);
      if (m == len) begin
        rl = (rep_len_reg > 16) ? 16 : int'(rep_len_reg);
        for (int i = 0; i < rl; i++) emit_byte(rep_bytes[i*8 +: 8], n);
        m = 0;
      end
    end
    match_len = m[4:0];
    if (n > 0) pending_bytes[pending_bytes.size()-1].last_of_run = 1'b1;
  endfunction

  // Offer one request and hold it until taken; push stays high unless a random pause follows
  task automatic send_request(sfr_pkg::in_item_t r);
    push <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (full);
    rewrite_request(r);
    requests_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Drain all expected bytes, then let the engine settle
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then idle the channel before returning
  task automatic write_register(logic [2:0] idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, v);
    @(posedge clk);
  endtask

  function automatic void add_text(logic [7:0] b, bit typed = 0);
    rows.push_back('{ROW_TEXT, b, '0, '0, typed, b});
  endfunction

  function automatic void add_eol(bit typed = 0);
    rows.push_back('{ROW_EOL, '0, '0, '0, typed, sfr_pkg::NEWLINE});
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [63:0] v);
    rows.push_back('{ROW_CFG, '0, idx, v, 1'b0, '0});
  endfunction

  // Check each popped byte against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result byte %h", out_data.out_byte);
        errors++;
      end else begin
        sfr_pkg::out_item_t want;
        want = pending_bytes.pop_front();
        results_checked++;
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte expected %h actual %h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %b actual %b", want.last_of_run,
                 out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // Receiver: random pop bursts, one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet && !hold_req && $urandom_range(0, 1) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin
    sfr_pkg::in_item_t r;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    logic [63:0] w;
    int          n0;
    int          burst;
    int          plen;
    string       txt;

    pat_bytes = '0;
    rep_bytes = '0;
    pat_len_reg = '0;
    rep_len_reg = '0;
    match_len = '0;
    rebuild_fallback();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pass-through after reset, then small and extreme patterns
    add_text(8'h00, 1);
    add_text(8'hFF, 1);
    add_eol(1);
    add_cfg(sfr_pkg::REG_PAT_LO, 64'h0000_0000_6261_6261);
    add_cfg(sfr_pkg::REG_PAT_LEN, 64'd4);
    add_cfg(sfr_pkg::REG_REP_LO, 64'h0000_0000_0000_5958);
    add_cfg(sfr_pkg::REG_REP_LEN, 64'd2);
    txt = "ababaaba";
    foreach (txt[i]) add_text(txt[i]);
    add_eol();
    add_text("a"); add_text("b"); add_text("a");
    add_eol();
    add_cfg(sfr_pkg::REG_PAT_LO, '1);
    add_cfg(sfr_pkg::REG_PAT_HI, '1);
    add_cfg(sfr_pkg::REG_PAT_LEN, 64'd31);
    add_cfg(sfr_pkg::REG_REP_HI, '1);
    add_cfg(sfr_pkg::REG_REP_LEN, 64'd31);
    add_text(8'hFF); add_text(8'hFF); add_text(8'hFF);
    add_eol();
    add_cfg(sfr_pkg::REG_PAT_LEN, 64'd1);
    add_cfg(sfr_pkg::REG_REP_LEN, 64'd0);
    add_text(8'hFF); add_text(8'h00);
    add_cfg(sfr_pkg::REG_PAT_LEN, 64'd2);
    add_text(8'hFF);
    add_cfg(sfr_pkg::REG_PAT_LEN, 64'd2);
    add_cfg(REG_UNUSED, '1);
    add_eol();
    add_cfg(sfr_pkg::REG_PAT_LEN, 64'd16);
    add_cfg(sfr_pkg::REG_REP_LEN, 64'd16);
    add_text(8'hFF); add_text(8'h7E);
    add_eol();

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(rows[i].idx, rows[i].wdata);
      end else begin
        r.func = (rows[i].kind == ROW_EOL) ? sfr_pkg::FUNC_EOL : sfr_pkg::FUNC_TEXT;
        r.data_byte = rows[i].data;
        n0 = pending_bytes.size();
        send_request(r);
        if (rows[i].typed) begin
          while (pending_bytes.size() > n0) void'(pending_bytes.pop_back());
          pending_bytes.push_back('{rows[i].typed_byte, 1'b1});
        end
      end
    end

    // Random phases: new pattern over a two-symbol alphabet, then text
    requests_sent = 0;
    while (requests_sent < NUM_RANDOM) begin
      wait_idle();
      phases++;
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      for (int reg_i = 0; reg_i < 2; reg_i++) begin
        for (int b = 0; b < 8; b++) w[b*8 +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
        write_register(reg_i == 0 ? sfr_pkg::REG_PAT_LO : sfr_pkg::REG_PAT_HI, w);
      end
      case ($urandom_range(0, 9))
        0: plen = 0;
        1: plen = 16;
        2: plen = $urandom_range(17, 31);
        default: plen = $urandom_range(1, 6);
      endcase
      w = {$urandom, $urandom};
      write_register(sfr_pkg::REG_PAT_LEN, {w[63:5], plen[4:0]});
      write_register(sfr_pkg::REG_REP_LO, {$urandom, $urandom});
      write_register(sfr_pkg::REG_REP_HI, {$urandom, $urandom});
      w = {$urandom, $urandom};
      w[4:0] = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 4));
      write_register(sfr_pkg::REG_REP_LEN, w);
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED + 3'($urandom_range(0, 1)),
                                                    {$urandom, $urandom});
      if (phases == 2) hold_req = 1'b1;

      burst = $urandom_range(20, 40);
      for (int k = 0; k < burst && requests_sent < NUM_RANDOM; k++) begin
        quiet = (requests_sent >= NUM_RANDOM - QUIET_TAIL);
        if ($urandom_range(0, 5) == 0 && plen > 0) begin
          // full copy of the pattern to force a match
          for (int j = 0; j < ((plen > 16) ? 16 : plen); j++) begin
            r.func = sfr_pkg::FUNC_TEXT;
            r.data_byte = pat_at(j);
            send_request(r);
          end
        end else begin
          r.func = ($urandom_range(0, 11) == 0) ? sfr_pkg::FUNC_EOL : sfr_pkg::FUNC_TEXT;
          r.data_byte = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                      : ($urandom_range(0, 1) ? sym_a : sym_b);
          send_request(r);
        end
      end
    end

    quiet = 1'b1;
    wait_idle();
    $display("Run covered the directed table plus %0d random phases.", phases);
    $display("Checked %0d result bytes with %0d mismatches.", results_checked, errors);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
